/* hdl/fre_pkg.sv */
// ----------------------------------------------------------------------------
// fre_pkg
// Types and constants shared by the four-rate envelope top level and its
// step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fre_pkg;

   localparam int unsigned LEVEL_W  = 28;
   localparam int unsigned RATE_W   = 7;
   localparam int unsigned OFFSET_W = 5;
   localparam int unsigned NUM_RATES = 4;

   localparam logic [LEVEL_W-1:0] JUMP_LEVEL   = 28'd112459776;
   localparam logic [LEVEL_W-1:0] SILENT_LEVEL = 28'd1048576;
   localparam logic [LEVEL_W:0]   CEIL_LEVEL   = 29'd285212672;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_OFF   = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ATTACK  = 3'd1;
   localparam logic [2:0] PH_DECAY   = 3'd2;
   localparam logic [2:0] PH_SUSTAIN = 3'd3;
   localparam logic [2:0] PH_RELEASE = 3'd4;

   typedef struct packed {
      logic [1:0]                           mode;
      logic [NUM_RATES-1:0][LEVEL_W-1:0]    targets;
      logic [OFFSET_W-1:0]                  offset;
   } cmd_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]                   level;
      logic [2:0]                           phase;
      logic [NUM_RATES-1:0][LEVEL_W-1:0]    targets;
      logic [OFFSET_W-1:0]                  offset;
   } env_state_type;

endpackage

/* hdl/fm_four_rate_envelope.sv */
// ----------------------------------------------------------------------------
// fm_four_rate_envelope
// Four-rate, four-level envelope in the log domain, one request per cycle when not stalled.
// ----------------------------------------------------------------------------
// Requests enter on req_*: tuser carries the mode (tick, note-on, note-off,
// clear), tdata the four target levels and the key rate offset, which only a
// note-on takes. Every request yields exactly one response on rsp_*: the
// level and phase after that request.
// An accepted request is loaded into the request register, its step result
// into the response register once that is free. Throughput is one request
// per clock while the receiver does not stall; the level and phase registers
// close their loop through a single step unit. When the receiver stalls, the
// response register holds and the request register fills; req_tready drops
// only while both are full. Rates must be written through csr_* by index
// (attack, decay, sustain, release) only while no request is in flight; the
// block does not enforce this. Synchronous reset clears the rates, level,
// held targets and offset, sets the phase to idle and empties both stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fm_four_rate_envelope (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [27:0] first_target, [55:28] second_target, [83:56] third_target,
   // [111:84] fourth_target, [116:112] key_rate_offset, [119:117] zero
   input  logic [119:0]  req_tdata,
   // [1:0] mode
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [27:0] log_level, [31:28] zero
   output logic [31:0]   rsp_tdata,
   // [2:0] phase
   output logic [2:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [6:0]    csr_wdata
);

   fre_pkg::env_state_type                                 state_ff, state_in;
   fre_pkg::cmd_type                                       cmd_ff, cmd_in;
   logic [fre_pkg::NUM_RATES-1:0][fre_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic                                                   cmd_valid_ff, cmd_valid_in;
   logic                                                   rsp_valid_ff, rsp_valid_in;
   logic [fre_pkg::LEVEL_W-1:0]                            rsp_level_ff, rsp_level_in;
   logic [2:0]                                             rsp_phase_ff, rsp_phase_in;
   fre_pkg::env_state_type                                 step_nxt;
   logic                                                   req_take;
   logic                                                   advance;

   fre_step u_step (
      .cur   (state_ff),
      .cmd   (cmd_ff),
      .rates (rate_ff),
      .nxt   (step_nxt)
   );

   assign advance    = cmd_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !cmd_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      cmd_in.mode       = req_tuser;
      cmd_in.targets[0] = req_tdata[27:0];
      cmd_in.targets[1] = req_tdata[55:28];
      cmd_in.targets[2] = req_tdata[83:56];
      cmd_in.targets[3] = req_tdata[111:84];
      cmd_in.offset     = req_tdata[116:112];

      cmd_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : cmd_valid_ff);
      state_in     = advance ? step_nxt : state_ff;

      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_level_in = advance ? step_nxt.level : rsp_level_ff;
      rsp_phase_in = advance ? step_nxt.phase : rsp_phase_ff;

      rate_in = rate_ff;
      if (csr_we) begin
         rate_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= '0;
         state_ff     <= '0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= cmd_in;
      end
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_level_ff};
   assign rsp_tuser  = rsp_phase_ff;

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_level_ff == state_ff.level) && (rsp_phase_ff == state_ff.phase))
      else $error("response differs from envelope state");

   a_clear_to_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.mode == fre_pkg::MODE_CLEAR)
      |=> (state_ff.phase == fre_pkg::PH_IDLE) && (state_ff.level == '0))
      else $error("clear did not reach idle");

   a_note_on_starts: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.mode == fre_pkg::MODE_ON)
      |=> (state_ff.phase == fre_pkg::PH_ATTACK || state_ff.phase == fre_pkg::PH_DECAY))
      else $error("note-on did not start attack or decay");

   a_release_exit: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.mode == fre_pkg::MODE_TICK && state_ff.phase == fre_pkg::PH_RELEASE)
      |=> (state_ff.phase == fre_pkg::PH_RELEASE || state_ff.phase == fre_pkg::PH_IDLE))
      else $error("release left to a wrong phase");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("envelope state moved without a request");

endmodule

/* hdl/fre_step.sv */
// ----------------------------------------------------------------------------
// fre_step
// Next-state logic of the envelope: applies one request (tick, note-on,
// note-off or clear) to the current level, phase and held targets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fre_step (
   input  fre_pkg::env_state_type                                   cur,
   input  fre_pkg::cmd_type                                         cmd,
   input  logic [fre_pkg::NUM_RATES-1:0][fre_pkg::RATE_W-1:0]       rates,
   output fre_pkg::env_state_type                                   nxt
);

   logic [1:0]                    p_idx;
   logic [fre_pkg::LEVEL_W-1:0]   tgt;
   logic [fre_pkg::RATE_W-1:0]    rate;
   logic [12:0]                   scaled;
   logic [7:0]                    q_sum;
   logic [5:0]                    qrate;
   logic [2:0]                    mant;
   logic [4:0]                    shamt;
   logic [25:0]                   inc;
   logic [fre_pkg::LEVEL_W-1:0]   gap;
   logic                          fall_done;
   logic [fre_pkg::LEVEL_W-1:0]   fall_level;
   logic [fre_pkg::LEVEL_W-1:0]   base;
   logic [fre_pkg::LEVEL_W:0]     head;
   logic [4:0]                    mult;
   logic [30:0]                   prod;
   logic [31:0]                   rise_sum;
   logic                          rise_done;
   logic                          done;
   logic [fre_pkg::LEVEL_W-1:0]   moved;

   assign p_idx = 2'(cur.phase - fre_pkg::PH_ATTACK);
   assign tgt   = cur.targets[p_idx];
   assign rate  = rates[p_idx];

   // step rate and increment
   assign scaled = 13'(rate) * 13'd41;
   assign q_sum  = {1'b0, scaled[12:6]} + {3'b000, cur.offset};
   assign qrate  = (q_sum > 8'd63) ? 6'd63 : q_sum[5:0];
   assign mant   = {1'b1, qrate[1:0]};
   assign shamt  = 5'd8 + {1'b0, qrate[5:2]};
   assign inc    = 26'(mant) << shamt;

   // linear fall
   assign gap        = cur.level - tgt;
   assign fall_done  = {2'b00, inc} >= gap;
   assign fall_level = cur.level - 28'(inc);

   // jump-started rise
   assign base      = (cur.level < fre_pkg::JUMP_LEVEL) ? fre_pkg::JUMP_LEVEL : cur.level;
   assign head      = fre_pkg::CEIL_LEVEL - {1'b0, base};
   assign mult      = head[28:24];
   assign prod      = 31'(mult) * 31'(inc);
   assign rise_sum  = {4'b0000, base} + {1'b0, prod};
   assign rise_done = rise_sum >= {4'b0000, tgt};

   always_comb begin
      if (cur.level > tgt) begin
         done  = fall_done;
         moved = fall_done ? tgt : fall_level;
      end else if (cur.level < tgt) begin
         done  = rise_done;
         moved = rise_done ? tgt : rise_sum[27:0];
      end else begin
         done  = 1'b1;
         moved = cur.level;
      end
   end

   always_comb begin
      nxt = cur;
      case (cmd.mode)
         fre_pkg::MODE_ON: begin
            nxt.targets = cmd.targets;
            nxt.offset  = cmd.offset;
            if (cur.level <= fre_pkg::SILENT_LEVEL || cur.phase == fre_pkg::PH_IDLE) begin
               nxt.level = '0;
               nxt.phase = fre_pkg::PH_ATTACK;
            end else begin
               nxt.phase = (cur.level >= cmd.targets[0]) ? fre_pkg::PH_DECAY
                                                         : fre_pkg::PH_ATTACK;
            end
         end
         fre_pkg::MODE_OFF: begin
            if (cur.phase != fre_pkg::PH_RELEASE && cur.phase != fre_pkg::PH_IDLE) begin
               nxt.phase = fre_pkg::PH_RELEASE;
            end
         end
         fre_pkg::MODE_CLEAR: begin
            nxt.phase = fre_pkg::PH_IDLE;
            nxt.level = '0;
         end
         default: begin
            case (cur.phase)
               fre_pkg::PH_ATTACK, fre_pkg::PH_DECAY,
               fre_pkg::PH_SUSTAIN, fre_pkg::PH_RELEASE: begin
                  nxt.level = moved;
                  if (done && cur.phase != fre_pkg::PH_SUSTAIN) begin
                     nxt.phase = (cur.phase == fre_pkg::PH_RELEASE) ? fre_pkg::PH_IDLE
                                                                    : 3'(cur.phase + 3'd1);
                  end
               end
               default: begin
                  nxt.phase = fre_pkg::PH_IDLE;
                  nxt.level = cur.targets[3];
               end
            endcase
         end
      endcase
   end

endmodule

/* tb/sv/fm_four_rate_envelope_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_four_rate_envelope_tb
// Self-checking testbench for the four-rate log-domain envelope.
// A scoreboard object keeps its own copy of the rates, level, phase, held
// targets and key rate offset. It predicts the level and phase that every
// accepted request yields, and it checks each response against the oldest
// prediction. A short directed run covers the idle tick, note-on from
// silence, retrigger above and below the first target, sustain hold, double
// note-off, release to idle and clear. Random note sequences follow, under
// several rate settings and four pacing profiles on both handshakes.
// ----------------------------------------------------------------------------

module fm_four_rate_envelope_tb;

   typedef logic [fre_pkg::RATE_W-1:0]   rate_type;
   typedef logic [fre_pkg::LEVEL_W-1:0]  level_type;
   typedef logic [fre_pkg::OFFSET_W-1:0] offset_type;

   localparam logic [1:0] RATE_ATTACK  = 2'd0;
   localparam logic [1:0] RATE_DECAY   = 2'd1;
   localparam logic [1:0] RATE_SUSTAIN = 2'd2;
   localparam logic [1:0] RATE_RELEASE = 2'd3;

   localparam rate_type  RATE_MAX  = '1;
   localparam level_type LEVEL_MAX = '1;

   localparam int unsigned SEGMENTS      = 8;
   localparam int unsigned SEGMENT_ITEMS = 88;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   typedef struct {
      level_type  level;
      logic [2:0] phase;
   } envelope_point_type;

   class envelope_scoreboard;
      rate_type            rates [fre_pkg::NUM_RATES];
      logic [31:0]         level;
      logic [2:0]          phase;
      level_type           targets [fre_pkg::NUM_RATES];
      offset_type          offset;
      envelope_point_type  upcoming [$];
      int unsigned         failures;
      int unsigned         checked;
      int unsigned         phase_hits [5];

      function new();
         foreach (rates[i]) begin
            rates[i] = '0;
            targets[i] = '0;
         end
         foreach (phase_hits[i]) phase_hits[i] = 0;
         level = '0;
         phase = fre_pkg::PH_IDLE;
         offset = '0;
         failures = 0;
         checked = 0;
      endfunction

      function void set_rate(logic [1:0] index, rate_type value);
         rates[index] = value;
      endfunction

      function int unsigned outstanding();
         return upcoming.size();
      endfunction

      function longint unsigned step_size(rate_type rate);
         int unsigned         r;
         int unsigned         q;
         longint unsigned     inc;
         r = 32'(rate);
         q = ((r * 32'd41) >> 6) + 32'(offset);
         if (q > 32'd63) q = 32'd63;
         inc = 64'(32'd4 + (q & 32'd3));
         return inc << (32'd8 + (q >> 2));
      endfunction

      function bit move_level(level_type goal, longint unsigned inc);
         longint unsigned lv;
         if (level > 32'(goal)) begin
            lv = 64'(level) - 64'(goal);
            if (inc >= lv) begin
               level = 32'(goal);
               return 1'b1;
            end
            lv = 64'(level) - inc;
            level = lv[31:0];
            return 1'b0;
         end
         if (level < 32'(goal)) begin
            lv = 64'(level);
            if (lv < 64'(fre_pkg::JUMP_LEVEL)) lv = 64'(fre_pkg::JUMP_LEVEL);
            lv = lv + ((64'(fre_pkg::CEIL_LEVEL) - lv) >> 24) * inc;
            if (lv >= 64'(goal)) begin
               level = 32'(goal);
               return 1'b1;
            end
            level = lv[31:0];
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void advance_envelope(logic [1:0] mode, logic [119:0] data);
         int unsigned idx;
         bit          reached;
         case (mode)
            fre_pkg::MODE_ON: begin
               foreach (targets[i]) targets[i] = data[i*fre_pkg::LEVEL_W +: fre_pkg::LEVEL_W];
               offset = data[fre_pkg::NUM_RATES*fre_pkg::LEVEL_W +: fre_pkg::OFFSET_W];
               if (level <= 32'(fre_pkg::SILENT_LEVEL) || phase == fre_pkg::PH_IDLE) begin
                  level = '0;
                  phase = fre_pkg::PH_ATTACK;
               end else begin
                  phase = (level >= 32'(targets[0])) ? fre_pkg::PH_DECAY
                                                      : fre_pkg::PH_ATTACK;
               end
            end
            fre_pkg::MODE_OFF: begin
               if (phase != fre_pkg::PH_RELEASE && phase != fre_pkg::PH_IDLE)
                  phase = fre_pkg::PH_RELEASE;
            end
            fre_pkg::MODE_CLEAR: begin
               phase = fre_pkg::PH_IDLE;
               level = '0;
            end
            default: begin
               if (phase >= fre_pkg::PH_ATTACK && phase <= fre_pkg::PH_RELEASE) begin
                  idx = 32'(phase - fre_pkg::PH_ATTACK);
                  reached = move_level(targets[idx], step_size(rates[idx]));
                  if (reached && phase != fre_pkg::PH_SUSTAIN)
                     phase = (phase == fre_pkg::PH_RELEASE) ? fre_pkg::PH_IDLE
                                                            : 3'(phase + 3'd1);
               end else begin
                  phase = fre_pkg::PH_IDLE;
                  level = 32'(targets[fre_pkg::NUM_RATES-1]);
               end
            end
         endcase
      endfunction

      function void note_request(logic [1:0] mode, logic [119:0] data);
         advance_envelope(mode, data);
         upcoming.push_back('{level[fre_pkg::LEVEL_W-1:0], phase});
      endfunction

      function void check_response(logic [31:0] tdata, logic [2:0] tuser);
         envelope_point_type want;
         if (upcoming.size() == 0) begin
            $error("response with no request pending: log_level %0h phase %0d",
                   tdata[fre_pkg::LEVEL_W-1:0], tuser);
            failures++;
            return;
         end
         want = upcoming.pop_front();
         checked++;
         if (tdata[fre_pkg::LEVEL_W-1:0] !== want.level) begin
            $error("log_level expected %0h actual %0h", want.level,
                   tdata[fre_pkg::LEVEL_W-1:0]);
            failures++;
         end
         if (tuser !== want.phase) begin
            $error("phase expected %0d actual %0d", want.phase, tuser);
            failures++;
         end
         if (want.phase <= fre_pkg::PH_RELEASE) phase_hits[want.phase]++;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [119:0]        req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [31:0]         rsp_tdata;
   logic [2:0]          rsp_tuser;
   logic                csr_we;
   logic [1:0]          csr_index;
   rate_type            csr_wdata;

   int unsigned         idle_pct;
   int unsigned         stall_pct;
   int unsigned         cycle_count;
   int unsigned         requests_sent;
   int unsigned         rate_settings;
   envelope_scoreboard  sb;

   fm_four_rate_envelope dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, sb.outstanding());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic level_type random_level();
      logic [31:0] w;
      w = $urandom;
      return w[fre_pkg::LEVEL_W-1:0];
   endfunction

   function automatic rate_type pick_rate();
      return $urandom_range(1) ? rate_type'($urandom_range(80, RATE_MAX))
                               : rate_type'($urandom_range(0, RATE_MAX));
   endfunction

   task automatic send_request(input logic [1:0] mode,
                               input level_type t0, t1, t2, t3,
                               input offset_type offset);
      logic [119:0] data;
      data = {3'b000, offset, t3, t2, t1, t0};
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_request(mode, data);
      requests_sent++;
   endtask

   task automatic send_filler(input logic [1:0] mode);
      send_request(mode, random_level(), random_level(), random_level(), random_level(),
                   offset_type'($urandom_range(0, 31)));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic write_rate(input logic [1:0] index, input rate_type value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_rate(index, value);
   endtask

   task automatic load_rates(input rate_type a, d, s, r);
      write_rate(RATE_ATTACK, a);
      write_rate(RATE_DECAY, d);
      write_rate(RATE_SUSTAIN, s);
      write_rate(RATE_RELEASE, r);
      csr_we <= 1'b0;
      rate_settings++;
   endtask

   task automatic set_pacing(input int unsigned profile);
      case (profile)
         0: begin
            idle_pct = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct = 50;
            stall_pct = 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct = 50;
         end
         default: begin
            idle_pct = 21;
            stall_pct = 21;
         end
      endcase
   endtask

   task automatic run_directed();
      send_filler(fre_pkg::MODE_TICK);
      send_filler(fre_pkg::MODE_OFF);
      send_request(fre_pkg::MODE_ON, LEVEL_MAX, 28'h8000000, 28'h4000000, '0, 5'd31);
      send_filler(fre_pkg::MODE_TICK);
      send_request(fre_pkg::MODE_ON, LEVEL_MAX, 28'h8000000, 28'h4000000, '0, '0);
      repeat (5) send_filler(fre_pkg::MODE_TICK);
      send_request(fre_pkg::MODE_ON, LEVEL_MAX, 28'h8000000, 28'h4000000, '0, '0);
      send_filler(fre_pkg::MODE_OFF);
      send_filler(fre_pkg::MODE_OFF);
      repeat (3) send_filler(fre_pkg::MODE_TICK);
      send_request(fre_pkg::MODE_ON, '0, '0, '0, '0, '0);
      send_filler(fre_pkg::MODE_TICK);
      send_request(fre_pkg::MODE_ON, '0, '0, fre_pkg::SILENT_LEVEL, LEVEL_MAX, 5'd31);
      send_filler(fre_pkg::MODE_TICK);
      send_filler(fre_pkg::MODE_TICK);
      send_filler(fre_pkg::MODE_OFF);
      send_filler(fre_pkg::MODE_TICK);
      send_filler(fre_pkg::MODE_CLEAR);
      send_filler(fre_pkg::MODE_TICK);
   endtask

   task automatic play_note();
      level_type   t [fre_pkg::NUM_RATES];
      level_type   base;
      int unsigned style;
      style = $urandom_range(3);
      base = random_level();
      foreach (t[i]) begin
         case (style)
            0: t[i] = random_level();
            1: t[i] = base + level_type'($urandom_range(0, 1 << 16));
            2: t[i] = $urandom_range(1) ? LEVEL_MAX : '0;
            default: t[i] = random_level() >> i;
         endcase
      end
      send_request(fre_pkg::MODE_ON, t[0], t[1], t[2], t[3],
                   offset_type'($urandom_range(0, 31)));
      repeat ($urandom_range(1, 20)) send_filler(fre_pkg::MODE_TICK);
      if ($urandom_range(7) != 0) send_filler(fre_pkg::MODE_OFF);
      repeat ($urandom_range(0, 12)) send_filler(fre_pkg::MODE_TICK);
   endtask

   task automatic run_segment(input int unsigned count);
      int unsigned stop;
      stop = requests_sent + count;
      while (requests_sent < stop) begin
         case ($urandom_range(9))
            0: send_filler(2'($urandom_range(0, 3)));
            1: send_filler($urandom_range(1) ? fre_pkg::MODE_OFF : fre_pkg::MODE_CLEAR);
            default: play_note();
         endcase
         if ($urandom_range(9) == 0) settle();
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = fre_pkg::MODE_TICK;
      csr_we = 1'b0;
      csr_index = RATE_ATTACK;
      csr_wdata = '0;
      set_pacing(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      load_rates(RATE_MAX, RATE_MAX, 7'd99, RATE_MAX);
      run_directed();
      settle();
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         set_pacing(seg % 4);
         if (seg == 0)
            load_rates(RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX);
         else if (seg == 1)
            load_rates('0, '0, '0, '0);
         else
            load_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
         run_segment(SEGMENT_ITEMS);
         settle();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests over %0d rate settings and four pacing profiles, %0d %s",
               requests_sent, rate_settings, sb.checked, "responses checked");
      $display("Responses per phase: idle %0d attack %0d decay %0d sustain %0d release %0d",
               sb.phase_hits[0], sb.phase_hits[1], sb.phase_hits[2], sb.phase_hits[3],
               sb.phase_hits[4]);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/fre_pkg.sv
hdl/fre_step.sv
hdl/fm_four_rate_envelope.sv
tb/sv/fm_four_rate_envelope_tb.sv
